[rtl/i2cra_pkg.sv]
// ----------------------------------------------------------------------------
// I2C register access master: shared definitions
// Phase codes, transaction payload types, register indexes and reset values.
// ----------------------------------------------------------------------------
package i2cra_pkg;

   // Control and status register map
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DEVICE_ADDRESS    = 2'd0,
      CSR_HALF_PERIOD_TICKS = 2'd1,
      CSR_ACK_POLL_LIMIT    = 2'd2,
      CSR_UNUSED            = 2'd3
   } csr_index_type;

   localparam logic [6:0]  DEVICE_ADDRESS_RESET    = 7'd81;
   localparam logic [15:0] HALF_PERIOD_TICKS_RESET = 16'd50;
   localparam logic [7:0]  ACK_POLL_LIMIT_RESET    = 8'd100;

   // Depth of the queue between front and back
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // Bus sequencer phases
   typedef enum logic [4:0] {
      PH_IDLE     = 5'd0,
      PH_START_HI = 5'd1,
      PH_START_LO = 5'd2,
      PH_TX_DEVW  = 5'd3,
      PH_ACK1     = 5'd4,
      PH_TX_REG   = 5'd5,
      PH_ACK2     = 5'd6,
      PH_TX_DATA  = 5'd7,
      PH_ACK3     = 5'd8,
      PH_RS_PREP  = 5'd9,
      PH_RS_HI    = 5'd10,
      PH_RS_LO    = 5'd11,
      PH_TX_DEVR  = 5'd12,
      PH_ACK4     = 5'd13,
      PH_RX       = 5'd14,
      PH_MNACK    = 5'd15,
      PH_STOP_A   = 5'd16,
      PH_STOP_B   = 5'd17,
      PH_STOP_C   = 5'd18
   } phase_type;

   // Request kinds
   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_READ  = 1'b1;

   // One tick of input
   typedef struct packed {
      logic       req_valid;
      logic       req_type;
      logic [7:0] reg_address;
      logic [7:0] write_data;
      logic       sda_sample;
   } item_type;

   // One tick of result
   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       sda_drive;
      logic       busy_res;
      logic [7:0] read_data;
      logic       done_res;
      logic       nack_seen;
   } result_type;

   // Queue head handed from front to back
   typedef struct packed {
      logic     valid;
      logic     start;
      item_type item;
   } queue_head_type;

endpackage

[rtl/i2cra_req_if.sv]
// ----------------------------------------------------------------------------
// I2C register access master: request channel
// One tick of bus inputs per transaction.
// ----------------------------------------------------------------------------
interface i2cra_req_if;
   logic       valid;
   logic       ready;
   logic       req_valid;
   logic       req_type;
   logic [7:0] reg_address;
   logic [7:0] write_data;
   logic       sda_sample;

   modport source (output valid, req_valid, req_type, reg_address, write_data, sda_sample,
                   input ready);
   modport sink   (input valid, req_valid, req_type, reg_address, write_data, sda_sample,
                   output ready);
endinterface

[rtl/i2cra_rsp_if.sv]
// ----------------------------------------------------------------------------
// I2C register access master: response channel
// Line levels and status for one tick per transaction.
// ----------------------------------------------------------------------------
interface i2cra_rsp_if;
   logic       valid;
   logic       ready;
   logic       scl_level;
   logic       sda_level;
   logic       sda_drive;
   logic       busy_res;
   logic [7:0] read_data;
   logic       done_res;
   logic       nack_seen;

   modport source (output valid, scl_level, sda_level, sda_drive, busy_res, read_data,
                          done_res, nack_seen,
                   input ready);
   modport sink   (input valid, scl_level, sda_level, sda_drive, busy_res, read_data,
                         done_res, nack_seen,
                   output ready);
endinterface

[rtl/i2cra_csr_if.sv]
// ----------------------------------------------------------------------------
// I2C register access master: register write channel
// Index and data of one register write per transaction.
// ----------------------------------------------------------------------------
interface i2cra_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[rtl/i2cra_front.sv]
// ----------------------------------------------------------------------------
// I2C register access master: front end
// Accept ticks, flag transaction starts and hold them in a short queue.
// ----------------------------------------------------------------------------
module i2cra_front
   import i2cra_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic           clock,
   input  logic           reset,
   i2cra_req_if.sink      req_ch,
   input  logic           pop,
   output queue_head_type head
);
   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

   item_type         mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   item_type         push_item;
   logic             push;

   assign req_ch.ready = (count_ff != FULL_CNT);
   assign push         = req_ch.valid && req_ch.ready;

   always_comb begin
      push_item.req_valid   = req_ch.req_valid;
      push_item.req_type    = req_ch.req_type;
      push_item.reg_address = req_ch.reg_address;
      push_item.write_data  = req_ch.write_data;
      push_item.sda_sample  = req_ch.sda_sample;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   // Classify: a start request is a tick with the request line raised
   always_comb begin
      head.valid = (count_ff != '0);
      head.item  = mem_ff[rd_ptr_ff];
      head.start = head.item.req_valid;
   end

endmodule

[rtl/i2cra_back.sv]
// ----------------------------------------------------------------------------
// I2C register access master: back end
// Advance the bus sequencer one tick per queued transaction, hold registers.
// ----------------------------------------------------------------------------
module i2cra_back
   import i2cra_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  queue_head_type head,
   output logic           pop,
   i2cra_csr_if.sink      csr_ch,
   i2cra_rsp_if.source    rsp_ch
);
   logic [6:0]  dev_addr_ff;
   logic [15:0] half_ticks_ff;
   logic [7:0]  poll_limit_ff;

   phase_type   phase_ff, phase_in;
   logic [3:0]  bit_ff, bit_in;
   logic [15:0] tick_ff, tick_in;
   logic [7:0]  shift_ff, shift_in;
   logic [7:0]  held_reg_ff, held_reg_in;
   logic [7:0]  held_data_ff, held_data_in;
   logic        held_read_ff, held_read_in;
   logic [7:0]  rx_byte_ff, rx_byte_in;
   logic        nack_ff, nack_in;

   logic        rsp_valid_ff;
   result_type  rsp_ff, rsp_in;

   logic [15:0] half_len;
   logic [7:0]  poll_len;
   logic [16:0] tick_inc;
   logic [15:0] tick_wrap;
   logic        elapsed;
   logic        poll_hit;
   logic        enter_en;
   phase_type   enter_ph;
   logic [7:0]  dev_byte;
   logic [7:0]  rx_shift;

   function automatic phase_type next_phase(input phase_type p, input logic is_read);
      phase_type n;
      unique case (p)
         PH_ACK2:  n = is_read ? PH_RS_PREP : PH_TX_DATA;
         PH_ACK3:  n = PH_STOP_A;
         PH_STOP_C: n = PH_IDLE;
         default:  n = phase_type'(p + 5'd1);
      endcase
      return n;
   endfunction

   assign pop          = head.valid && (!rsp_valid_ff || rsp_ch.ready);
   assign csr_ch.ready = 1'b1;

   assign half_len  = (half_ticks_ff == '0) ? 16'd1 : half_ticks_ff;
   assign poll_len  = (poll_limit_ff == '0) ? 8'd1 : poll_limit_ff;
   assign tick_inc  = {1'b0, tick_ff} + 17'd1;
   assign tick_wrap = tick_inc[15:0];
   assign elapsed   = (tick_inc >= {1'b0, half_len});
   assign poll_hit  = (tick_wrap >= {8'd0, poll_len});
   assign dev_byte  = {dev_addr_ff, 1'b0};
   assign rx_shift  = {shift_ff[6:0], head.item.sda_sample};

   always_comb begin
      phase_in     = phase_ff;
      bit_in       = bit_ff;
      tick_in      = tick_ff;
      shift_in     = shift_ff;
      held_reg_in  = held_reg_ff;
      held_data_in = held_data_ff;
      held_read_in = held_read_ff;
      rx_byte_in   = rx_byte_ff;
      nack_in      = nack_ff;
      enter_en     = 1'b0;
      enter_ph     = PH_IDLE;

      rsp_in.scl_level = 1'b1;
      rsp_in.sda_level = 1'b1;
      rsp_in.sda_drive = 1'b1;
      rsp_in.done_res  = 1'b0;
      rsp_in.busy_res  = (phase_ff != PH_IDLE);

      // Line levels from the state before this tick
      unique case (phase_ff)
         PH_START_LO, PH_RS_LO, PH_STOP_B: begin
            rsp_in.sda_level = 1'b0;
         end
         PH_RS_PREP: begin
            rsp_in.scl_level = 1'b0;
         end
         PH_STOP_A: begin
            rsp_in.scl_level = 1'b0;
            rsp_in.sda_level = 1'b0;
         end
         PH_TX_DEVW, PH_TX_REG, PH_TX_DATA, PH_TX_DEVR: begin
            rsp_in.scl_level = bit_ff[0];
            rsp_in.sda_level = shift_ff[~bit_ff[3:1]];
         end
         PH_ACK1, PH_ACK2, PH_ACK3, PH_ACK4: begin
            rsp_in.scl_level = (bit_ff == 4'd1);
            rsp_in.sda_drive = 1'b0;
         end
         PH_RX: begin
            rsp_in.scl_level = bit_ff[0];
            rsp_in.sda_drive = 1'b0;
         end
         PH_MNACK: begin
            rsp_in.scl_level = bit_ff[0];
         end
         default: begin
         end
      endcase

      // Sequencer advance
      unique case (phase_ff)
         PH_IDLE: begin
            if (head.start) begin
               held_reg_in  = head.item.reg_address;
               held_data_in = head.item.write_data;
               held_read_in = (head.item.req_type == REQ_READ);
               nack_in      = 1'b0;
               enter_en     = 1'b1;
               enter_ph     = PH_START_HI;
            end
         end
         PH_START_HI, PH_START_LO, PH_RS_PREP, PH_RS_HI, PH_RS_LO, PH_STOP_A,
         PH_STOP_B: begin
            if (elapsed) begin
               enter_en = 1'b1;
               enter_ph = next_phase(phase_ff, held_read_ff);
            end else begin
               tick_in = tick_wrap;
            end
         end
         PH_STOP_C: begin
            if (elapsed) begin
               enter_en        = 1'b1;
               enter_ph        = PH_IDLE;
               rsp_in.done_res = 1'b1;
            end else begin
               tick_in = tick_wrap;
            end
         end
         PH_TX_DEVW, PH_TX_REG, PH_TX_DATA, PH_TX_DEVR: begin
            if (elapsed) begin
               tick_in = '0;
               if (bit_ff == 4'd15) begin
                  enter_en = 1'b1;
                  enter_ph = next_phase(phase_ff, held_read_ff);
               end else begin
                  bit_in = bit_ff + 4'd1;
               end
            end else begin
               tick_in = tick_wrap;
            end
         end
         PH_RX: begin
            if (elapsed) begin
               tick_in = '0;
               if (bit_ff[0]) begin
                  shift_in = rx_shift;
               end
               if (bit_ff == 4'd15) begin
                  rx_byte_in = rx_shift;
                  enter_en   = 1'b1;
                  enter_ph   = PH_MNACK;
               end else begin
                  bit_in = bit_ff + 4'd1;
               end
            end else begin
               tick_in = tick_wrap;
            end
         end
         PH_MNACK: begin
            if (elapsed) begin
               tick_in = '0;
               if (bit_ff != 4'd0) begin
                  enter_en = 1'b1;
                  enter_ph = PH_STOP_A;
               end else begin
                  bit_in = 4'd1;
               end
            end else begin
               tick_in = tick_wrap;
            end
         end
         PH_ACK1, PH_ACK2, PH_ACK3, PH_ACK4: begin
            if (bit_ff == 4'd1) begin
               if (!head.item.sda_sample) begin
                  bit_in  = 4'd2;
                  tick_in = '0;
               end else if (poll_hit) begin
                  nack_in = 1'b1;
                  bit_in  = 4'd2;
                  tick_in = '0;
               end else begin
                  tick_in = tick_wrap;
               end
            end else if (elapsed) begin
               tick_in = '0;
               if (bit_ff == 4'd0) begin
                  bit_in = 4'd1;
               end else begin
                  enter_en = 1'b1;
                  enter_ph = next_phase(phase_ff, held_read_ff);
               end
            end else begin
               tick_in = tick_wrap;
            end
         end
         default: begin
            enter_en = 1'b1;
            enter_ph = PH_IDLE;
         end
      endcase

      if (enter_en) begin
         phase_in = enter_ph;
         bit_in   = '0;
         tick_in  = '0;
         unique case (enter_ph)
            PH_TX_DEVW: shift_in = dev_byte;
            PH_TX_REG:  shift_in = held_reg_in;
            PH_TX_DATA: shift_in = held_data_in;
            PH_TX_DEVR: shift_in = dev_byte | 8'd1;
            default:    shift_in = shift_in;
         endcase
      end

      rsp_in.read_data = rx_byte_in;
      rsp_in.nack_seen = nack_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_addr_ff   <= DEVICE_ADDRESS_RESET;
         half_ticks_ff <= HALF_PERIOD_TICKS_RESET;
         poll_limit_ff <= ACK_POLL_LIMIT_RESET;
      end else if (csr_ch.valid) begin
         unique case (csr_index_type'(csr_ch.index))
            CSR_DEVICE_ADDRESS:    dev_addr_ff   <= csr_ch.data[6:0];
            CSR_HALF_PERIOD_TICKS: half_ticks_ff <= csr_ch.data;
            CSR_ACK_POLL_LIMIT:    poll_limit_ff <= csr_ch.data[7:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         bit_ff       <= '0;
         tick_ff      <= '0;
         shift_ff     <= '0;
         held_reg_ff  <= '0;
         held_data_ff <= '0;
         held_read_ff <= 1'b0;
         rx_byte_ff   <= '0;
         nack_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            phase_ff     <= phase_in;
            bit_ff       <= bit_in;
            tick_ff      <= tick_in;
            shift_ff     <= shift_in;
            held_reg_ff  <= held_reg_in;
            held_data_ff <= held_data_in;
            held_read_ff <= held_read_in;
            rx_byte_ff   <= rx_byte_in;
            nack_ff      <= nack_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.scl_level = rsp_ff.scl_level;
   assign rsp_ch.sda_level = rsp_ff.sda_level;
   assign rsp_ch.sda_drive = rsp_ff.sda_drive;
   assign rsp_ch.busy_res  = rsp_ff.busy_res;
   assign rsp_ch.read_data = rsp_ff.read_data;
   assign rsp_ch.done_res  = rsp_ff.done_res;
   assign rsp_ch.nack_seen = rsp_ff.nack_seen;

endmodule

[rtl/i2c_register_access_master.sv]
// ----------------------------------------------------------------------------
// I2C register access master
// Two-wire bus master for single-register writes and reads, one tick per
// transaction on the request channel.
// ----------------------------------------------------------------------------
// Every request transaction is one tick of the bus sequencer: it carries the
// start request fields and the sampled data line, and it yields exactly one
// response transaction with the line levels for that tick, busy, done, the
// last received byte and the nack flag. Throughput is one transaction per
// clock unless the response stalls. An accepted tick is registered into
// the request queue (QUEUE_DEPTH entries) and from its head into the
// response register. Either side may stall: the queue absorbs request
// bursts while the response register waits, and the sequencer advances
// only when a tick leaves the queue. A write runs start, device write
// byte, register address, data and stop, with an acknowledge poll after
// each byte; a read replaces the data byte with a repeated start, the
// device read byte, eight received bits MSB first, a master NACK clock
// and stop. Registers: device_address (index 0), half_period_ticks
// (index 1, ticks per line step, zero acts as one) and ack_poll_limit
// (index 2, ticks of acknowledge polling before nack, zero acts as one).
// Write registers only while no request or response transaction is pending;
// a write applies from the next tick on, even in the middle of a bus
// transaction, and a shorter half period ends the current step at once.
// ----------------------------------------------------------------------------
module i2c_register_access_master
   import i2cra_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   i2cra_req_if.sink   req_ch,
   i2cra_rsp_if.source rsp_ch,
   i2cra_csr_if.sink   csr_ch
);
   queue_head_type head;
   logic           pop;

   // Front: accept ticks and queue them
   i2cra_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .pop    (pop),
      .head   (head)
   );

   // Back: run the sequencer and hold the response
   i2cra_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .pop    (pop),
      .csr_ch (csr_ch),
      .rsp_ch (rsp_ch)
   );

endmodule

[rtl/i2cra_checker.sv]
// ----------------------------------------------------------------------------
// I2C register access master: port checker
// Watch the response channel for handshake and line-level consistency.
// ----------------------------------------------------------------------------
module i2cra_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_done,
   input logic rsp_busy,
   input logic rsp_sda_level,
   input logic rsp_sda_drive
);

   // Hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // Drop response valid after reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A finishing tick belongs to a running transaction
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done |-> rsp_busy)
      else $error("done without busy");

   // Released data line reads high
   a_release_high: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_sda_drive |-> rsp_sda_level)
      else $error("released data line not high");

   // Two finishes never come back to back
   a_done_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_done |=> !(rsp_valid && rsp_done && $stable(rsp_done)
         && !$past(rsp_valid && !rsp_ready)))
      else $error("back-to-back done");

endmodule

bind i2c_register_access_master i2cra_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_done      (rsp_ch.done_res),
   .rsp_busy      (rsp_ch.busy_res),
   .rsp_sda_level (rsp_ch.sda_level),
   .rsp_sda_drive (rsp_ch.sda_drive)
);
